// ===== rtl/array_extremes_with_positions_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the extremes block
// Clocked, reset-gated property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ARRAY_EXTREMES_WITH_POSITIONS_DEFINES_SVH
`define ARRAY_EXTREMES_WITH_POSITIONS_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define AEWP_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define AEWP_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aewp_pkg.sv =====
// ----------------------------------------------------------------------------
// aewp_pkg
// Shared types and constants of the streaming extremes block.
// ----------------------------------------------------------------------------
`default_nettype none

package aewp_pkg;

    // Default configuration
    localparam int DEF_MAX_ITEMS = 1024;
    localparam int DEF_DATA_BITS = 32;

    // Fixed result field widths
    localparam int RES_W  = 32;
    localparam int POS_W  = 10;
    localparam int KIND_W = 3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result kinds, emitted in this order
    typedef enum logic [KIND_W-1:0] {
        KIND_MAX  = 3'd0,
        KIND_MIN  = 3'd1,
        KIND_SMAX = 3'd2,
        KIND_SMIN = 3'd3,
        KIND_LNEG = 3'd4,
        KIND_SPOS = 3'd5
    } t_kind;

    // Per-item classification made by the front
    typedef struct packed {
        logic first;   // first element of the set
        logic second;  // second element of the set
        logic last;    // closes the set
    } t_item_flags;

    localparam int FLAGS_W = $bits(t_item_flags);

    // One stored result
    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic [POS_W-1:0]        pos;
        logic                    valid;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/aewp_fifo.sv =====
// ----------------------------------------------------------------------------
// aewp_fifo
// Small register-file queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module aewp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_din,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_dout,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wp;
    logic [AW:0]      r_rp;
    logic [AW:0]      n_wp;
    logic [AW:0]      n_rp;
    logic             wr_ok;
    logic             rd_ok;

    // Flag full and empty from the wrapped pointers
    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_dout  = r_mem[r_rp[AW-1:0]];

    // Advance pointers
    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        if (wr_ok) begin
            n_wp = r_wp + (AW+1)'(1);
        end
        if (rd_ok) begin
            n_rp = r_rp + (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp[AW-1:0]] <= i_din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aewp_front.sv =====
// ----------------------------------------------------------------------------
// aewp_front
// Accepts elements, assigns their index and classifies their place in the set.
// ----------------------------------------------------------------------------
`default_nettype none

module aewp_front #(
    parameter int MAX_ITEMS = aewp_pkg::DEF_MAX_ITEMS,
    parameter int DATA_BITS = aewp_pkg::DEF_DATA_BITS,
    localparam int CW = $clog2(MAX_ITEMS + 1),
    localparam int PW = $clog2(MAX_ITEMS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic signed [31:0]         i_value,
    input  wire logic                       i_last,
    input  wire logic                       i_q_full,
    output logic                            o_q_wr,
    output logic signed [DATA_BITS-1:0]     o_value,
    output logic [PW-1:0]                   o_idx,
    output aewp_pkg::t_item_flags           o_flags
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          beat;

    assign beat   = i_push && !i_q_full;
    assign o_q_wr = beat;

    // Reinterpret the element at the working width
    assign o_value = $signed(DATA_BITS'($unsigned(i_value)));

    // Saturate the index at the last slot
    assign o_idx = (r_count < CW'(MAX_ITEMS)) ? r_count[PW-1:0] : PW'(MAX_ITEMS - 1);

    // Classify the element
    assign o_flags.first  = (r_count == '0);
    assign o_flags.second = (r_count == CW'(1));
    assign o_flags.last   = i_last;

    // Count elements of the set, drop to zero after its last beat
    always_comb begin
        n_count = r_count;
        if (beat) begin
            if (i_last) begin
                n_count = '0;
            end else if (r_count < CW'(MAX_ITEMS)) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aewp_back.sv =====
// ----------------------------------------------------------------------------
// aewp_back
// Updates the extreme trackers and plays out six results per set.
// ----------------------------------------------------------------------------
`default_nettype none

module aewp_back #(
    parameter int MAX_ITEMS = aewp_pkg::DEF_MAX_ITEMS,
    parameter int DATA_BITS = aewp_pkg::DEF_DATA_BITS,
    localparam int PW = $clog2(MAX_ITEMS)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_empty,
    input  wire logic signed [DATA_BITS-1:0]     i_value,
    input  wire logic [PW-1:0]                   i_idx,
    input  wire aewp_pkg::t_item_flags           i_flags,
    output logic                                 o_q_rd,
    input  wire logic                            i_pop,
    output logic                                 o_empty,
    output logic [aewp_pkg::KIND_W-1:0]          o_kind,
    output logic signed [aewp_pkg::RES_W-1:0]    o_result_value,
    output logic [aewp_pkg::POS_W-1:0]           o_position,
    output logic                                 o_valid_res,
    output logic                                 o_end_of_run
);

    typedef logic signed [DATA_BITS-1:0] t_val;

    // Trackers
    t_val          r_top1, r_top2, r_bot1, r_bot2, r_neg, r_pos;
    logic [PW-1:0] r_top1_pos, r_top2_pos, r_bot1_pos, r_bot2_pos, r_neg_pos, r_pos_pos;
    logic          r_neg_seen, r_pos_seen;
    t_val          n_top1, n_top2, n_bot1, n_bot2, n_neg, n_pos;
    logic [PW-1:0] n_top1_pos, n_top2_pos, n_bot1_pos, n_bot2_pos, n_neg_pos, n_pos_pos;
    logic          n_neg_seen, n_pos_seen;

    // Result bank
    aewp_pkg::t_res  r_res [6];
    aewp_pkg::t_res  sel;
    aewp_pkg::t_kind r_kind;
    logic            r_busy;
    logic            bank_free;
    logic            take;
    logic            out_beat;

    assign out_beat  = i_pop && r_busy;
    assign bank_free = !r_busy || (out_beat && (r_kind == aewp_pkg::KIND_SPOS));
    assign take      = !i_q_empty && (!i_flags.last || bank_free);
    assign o_q_rd    = take;

    // Update trackers with the head element
    always_comb begin
        n_top1 = r_top1;  n_top1_pos = r_top1_pos;
        n_top2 = r_top2;  n_top2_pos = r_top2_pos;
        n_bot1 = r_bot1;  n_bot1_pos = r_bot1_pos;
        n_bot2 = r_bot2;  n_bot2_pos = r_bot2_pos;
        n_neg  = r_neg;   n_neg_pos  = r_neg_pos;  n_neg_seen = r_neg_seen;
        n_pos  = r_pos;   n_pos_pos  = r_pos_pos;  n_pos_seen = r_pos_seen;
        if (take) begin
            if (i_flags.first) begin
                n_top1 = i_value;  n_top1_pos = i_idx;
                n_bot1 = i_value;  n_bot1_pos = i_idx;
            end else begin
                // upper pair
                if (i_value > r_top1) begin
                    n_top2 = r_top1;   n_top2_pos = r_top1_pos;
                    n_top1 = i_value;  n_top1_pos = i_idx;
                end else if (i_value == r_top1) begin
                    if (i_flags.second || (r_top2 != r_top1)) begin
                        n_top2 = r_top1;  n_top2_pos = r_top1_pos;
                    end
                end else if (i_flags.second || (i_value > r_top2)) begin
                    n_top2 = i_value;  n_top2_pos = i_idx;
                end
                // lower pair
                if (i_value < r_bot1) begin
                    n_bot2 = r_bot1;   n_bot2_pos = r_bot1_pos;
                    n_bot1 = i_value;  n_bot1_pos = i_idx;
                end else if (i_value == r_bot1) begin
                    if (i_flags.second || (r_bot2 != r_bot1)) begin
                        n_bot2 = r_bot1;  n_bot2_pos = r_bot1_pos;
                    end
                end else if (i_flags.second || (i_value < r_bot2)) begin
                    n_bot2 = i_value;  n_bot2_pos = i_idx;
                end
            end
            // nearest to zero on each side
            if ((i_value < 0) && (!r_neg_seen || (i_value > r_neg))) begin
                n_neg = i_value;  n_neg_pos = i_idx;  n_neg_seen = 1'b1;
            end
            if ((i_value > 0) && (!r_pos_seen || (i_value < r_pos))) begin
                n_pos = i_value;  n_pos_pos = i_idx;  n_pos_seen = 1'b1;
            end
        end
    end

    // Hold tracker payload
    always_ff @(posedge i_clk) begin
        r_top1 <= n_top1;  r_top1_pos <= n_top1_pos;
        r_top2 <= n_top2;  r_top2_pos <= n_top2_pos;
        r_bot1 <= n_bot1;  r_bot1_pos <= n_bot1_pos;
        r_bot2 <= n_bot2;  r_bot2_pos <= n_bot2_pos;
        r_neg  <= n_neg;   r_neg_pos  <= n_neg_pos;
        r_pos  <= n_pos;   r_pos_pos  <= n_pos_pos;
    end

    // Clear the seen flags once the set closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_seen <= 1'b0;
            r_pos_seen <= 1'b0;
        end else if (take && i_flags.last) begin
            r_neg_seen <= 1'b0;
            r_pos_seen <= 1'b0;
        end else begin
            r_neg_seen <= n_neg_seen;
            r_pos_seen <= n_pos_seen;
        end
    end

    // Capture the six results on the last element
    always_ff @(posedge i_clk) begin
        if (take && i_flags.last) begin
            r_res[0] <= '{aewp_pkg::RES_W'(n_top1), aewp_pkg::POS_W'(n_top1_pos), 1'b1};
            r_res[1] <= '{aewp_pkg::RES_W'(n_bot1), aewp_pkg::POS_W'(n_bot1_pos), 1'b1};
            r_res[2] <= i_flags.first ? '0 : aewp_pkg::t_res'{
                aewp_pkg::RES_W'(n_top2), aewp_pkg::POS_W'(n_top2_pos), 1'b1};
            r_res[3] <= i_flags.first ? '0 : aewp_pkg::t_res'{
                aewp_pkg::RES_W'(n_bot2), aewp_pkg::POS_W'(n_bot2_pos), 1'b1};
            r_res[4] <= !n_neg_seen ? '0 : aewp_pkg::t_res'{
                aewp_pkg::RES_W'(n_neg), aewp_pkg::POS_W'(n_neg_pos), 1'b1};
            r_res[5] <= !n_pos_seen ? '0 : aewp_pkg::t_res'{
                aewp_pkg::RES_W'(n_pos), aewp_pkg::POS_W'(n_pos_pos), 1'b1};
        end
    end

    // Advance through the bank one result beat at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= aewp_pkg::KIND_MAX;
        end else if (take && i_flags.last) begin
            r_busy <= 1'b1;
            r_kind <= aewp_pkg::KIND_MAX;
        end else if (out_beat) begin
            if (r_kind == aewp_pkg::KIND_SPOS) begin
                r_busy <= 1'b0;
            end else begin
                r_kind <= aewp_pkg::t_kind'(r_kind + aewp_pkg::KIND_W'(1));
            end
        end
    end

    // Select the current result
    always_comb begin
        unique case (r_kind)
            aewp_pkg::KIND_MAX:  sel = r_res[0];
            aewp_pkg::KIND_MIN:  sel = r_res[1];
            aewp_pkg::KIND_SMAX: sel = r_res[2];
            aewp_pkg::KIND_SMIN: sel = r_res[3];
            aewp_pkg::KIND_LNEG: sel = r_res[4];
            aewp_pkg::KIND_SPOS: sel = r_res[5];
            default:             sel = r_res[0];
        endcase
    end

    assign o_empty        = !r_busy;
    assign o_kind         = r_kind;
    assign o_result_value = sel.value;
    assign o_position     = sel.pos;
    assign o_valid_res    = sel.valid;
    assign o_end_of_run   = (r_kind == aewp_pkg::KIND_SPOS);

endmodule

`default_nettype wire

// ===== rtl/array_extremes_with_positions.sv =====
// Results: a set's six results are registered into the bank when the back takes its last
// element from the queue; the bank then presents them on the ports in kind order.
// Throughput: one element per cycle unless the queue is full, set by the tracker update in the back stage.
// Each set plays out six result beats, one per cycle while pop is high; a last element waits in the
// queue while the result bank of the previous set still drains.
// Reset: synchronous active-low i_rst_n empties the queue, the index counter and the bank.
// ----------------------------------------------------------------------------
// array_extremes_with_positions
// Streaming max, min, second max/min and nearest-to-zero values with first indices.
// ----------------------------------------------------------------------------
`default_nettype none

module array_extremes_with_positions #(
    parameter int MAX_ITEMS = aewp_pkg::DEF_MAX_ITEMS,
    parameter int DATA_BITS = aewp_pkg::DEF_DATA_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [31:0]            i_value,
    input  wire logic                          i_last,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [aewp_pkg::KIND_W-1:0]        o_kind,
    output logic signed [aewp_pkg::RES_W-1:0]  o_result_value,
    output logic [aewp_pkg::POS_W-1:0]         o_position,
    output logic                               o_valid_res,
    output logic                               o_end_of_run
);

    localparam int PW = $clog2(MAX_ITEMS);
    localparam int QW = DATA_BITS + PW + aewp_pkg::FLAGS_W;

    logic                        q_wr;
    logic                        q_rd;
    logic                        q_empty;
    logic [QW-1:0]               q_din;
    logic [QW-1:0]               q_dout;
    logic signed [DATA_BITS-1:0] f_value;
    logic [PW-1:0]               f_idx;
    aewp_pkg::t_item_flags       f_flags;
    logic signed [DATA_BITS-1:0] b_value;
    logic [PW-1:0]               b_idx;
    aewp_pkg::t_item_flags       b_flags;

    // Front: index and classify
    aewp_front #(
        .MAX_ITEMS (MAX_ITEMS),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_value  (i_value),
        .i_last   (i_last),
        .i_q_full (full),
        .o_q_wr   (q_wr),
        .o_value  (f_value),
        .o_idx    (f_idx),
        .o_flags  (f_flags)
    );

    assign q_din = {f_flags, f_idx, f_value};

    // Queue between front and back
    aewp_fifo #(
        .WIDTH (QW),
        .DEPTH (aewp_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_din   (q_din),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_dout  (q_dout),
        .o_empty (q_empty)
    );

    assign {b_flags, b_idx, b_value} = q_dout;

    // Back: track and play out
    aewp_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_value        (b_value),
        .i_idx          (b_idx),
        .i_flags        (b_flags),
        .o_q_rd         (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_kind         (o_kind),
        .o_result_value (o_result_value),
        .o_position     (o_position),
        .o_valid_res    (o_valid_res),
        .o_end_of_run   (o_end_of_run)
    );

endmodule

`default_nettype wire

// ===== rtl/aewp_checker.sv =====
// ----------------------------------------------------------------------------
// aewp_checker
// Port-level checks on the result stream of the extremes block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_extremes_with_positions_defines.svh"

module aewp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic [aewp_pkg::KIND_W-1:0]   o_kind,
    input wire logic signed [aewp_pkg::RES_W-1:0] o_result_value,
    input wire logic [aewp_pkg::POS_W-1:0]    o_position,
    input wire logic                          o_valid_res,
    input wire logic                          o_end_of_run
);

    // A stalled result beat holds its kind
    `AEWP_ASSERT_NEXT(a_hold_kind, !empty && !pop, !empty && $stable(o_kind), "result kind moved while stalled")

    // Kinds run in order within a set
    `AEWP_ASSERT_NEXT(a_kind_order, pop && !empty && !o_end_of_run, !empty && (o_kind == 3'($past(o_kind) + 3'd1)), "result kinds out of order")

    // The run ends on the smallest-positive result only
    `AEWP_ASSERT_NOW(a_end_kind, !empty, o_end_of_run == (o_kind == aewp_pkg::KIND_SPOS), "end of run on wrong kind")

    // Max and min always exist
    `AEWP_ASSERT_NOW(a_minmax_valid, !empty && ((o_kind == aewp_pkg::KIND_MAX) || (o_kind == aewp_pkg::KIND_MIN)), o_valid_res, "max or min flagged invalid")

    // Missing results carry zero payload
    `AEWP_ASSERT_NOW(a_invalid_zero, !empty && !o_valid_res, (o_result_value == 0) && (o_position == 0), "invalid result with nonzero payload")

endmodule

bind array_extremes_with_positions aewp_checker u_aewp_checker (.*);

`default_nettype wire

// ===== dv/array_extremes_with_positions_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_extremes_with_positions_tb
// Streams signed sets through the extremes block and checks every result beat
// (max, min, second max/min, largest negative, smallest positive, each with
// its first index) against a cycle-free model kept in step with accepted
// elements. Directed sets cover single elements, duplicates, missing signs,
// field extremes and index saturation. Random sets then run under several
// idle and stall mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module array_extremes_with_positions_tb;

    import aewp_pkg::*;

    localparam int SET_LIMIT    = DEF_MAX_ITEMS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // One expected result beat
    typedef struct packed {
        t_kind                   kind;
        logic signed [RES_W-1:0] value;
        logic [POS_W-1:0]        pos;
        logic                    valid;
        logic                    eor;
    } extreme_beat_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    pop = 1'b0;
    logic signed [31:0]      i_value = '0;
    logic                    i_last = 1'b0;
    logic                    full;
    logic                    empty;
    logic [KIND_W-1:0]       o_kind;
    logic signed [RES_W-1:0] o_result_value;
    logic [POS_W-1:0]        o_position;
    logic                    o_valid_res;
    logic                    o_end_of_run;

    // Model state of the trackers
    logic signed [31:0] max_val, max2_val, min_val, min2_val, neg_val, pos_val;
    logic [POS_W-1:0]   max_pos, max2_pos, min_pos, min2_pos, neg_pos, pos_pos;
    logic               neg_found, pos_found;
    logic [10:0]        set_count;

    extreme_beat_t pending_extremes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int errors_seen    = 0;
    int elements_sent  = 0;
    int sets_sent      = 0;
    int beats_checked  = 0;
    int cycle_count    = 0;

    array_extremes_with_positions i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_value        (i_value),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_result_value (o_result_value),
        .o_position     (o_position),
        .o_valid_res    (o_valid_res),
        .o_end_of_run   (o_end_of_run)
    );

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     pending_extremes.size());
            $display("array_extremes_with_positions_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        errors_seen++;
    endtask

    task automatic clear_trackers();
        max_val = '0; max2_val = '0; min_val = '0; min2_val = '0;
        neg_val = '0; pos_val = '0;
        max_pos = '0; max2_pos = '0; min_pos = '0; min2_pos = '0;
        neg_pos = '0; pos_pos = '0;
        neg_found = 1'b0; pos_found = 1'b0;
        set_count = '0;
    endtask

    task automatic queue_extreme(input t_kind k, input logic signed [31:0] v,
                                 input logic [POS_W-1:0] p, input logic ok);
        extreme_beat_t b;
        b.kind  = k;
        b.value = ok ? v : '0;
        b.pos   = ok ? p : '0;
        b.valid = ok;
        b.eor   = (k == KIND_SPOS);
        pending_extremes.push_back(b);
    endtask

    // Update the trackers with one accepted element; queue six beats on last
    task automatic track_element(input logic signed [31:0] v, input logic last_f);
        logic [POS_W-1:0] idx;
        logic             second_empty;
        idx = (set_count < SET_LIMIT) ? set_count[POS_W-1:0] : POS_W'(SET_LIMIT - 1);
        if (set_count == 0) begin
            max_val = v; min_val = v;
            max_pos = idx; min_pos = idx;
        end else begin
            second_empty = (set_count == 1);
            // upper pair
            if (v > max_val) begin
                max2_val = max_val; max2_pos = max_pos;
                max_val = v; max_pos = idx;
            end else if (v == max_val) begin
                if (second_empty || max2_val != max_val) begin
                    max2_val = max_val; max2_pos = max_pos;
                end
            end else if (second_empty || v > max2_val) begin
                max2_val = v; max2_pos = idx;
            end
            // lower pair
            if (v < min_val) begin
                min2_val = min_val; min2_pos = min_pos;
                min_val = v; min_pos = idx;
            end else if (v == min_val) begin
                if (second_empty || min2_val != min_val) begin
                    min2_val = min_val; min2_pos = min_pos;
                end
            end else if (second_empty || v < min2_val) begin
                min2_val = v; min2_pos = idx;
            end
        end
        if (v < 0 && (!neg_found || v > neg_val)) begin
            neg_val = v; neg_pos = idx; neg_found = 1'b1;
        end
        if (v > 0 && (!pos_found || v < pos_val)) begin
            pos_val = v; pos_pos = idx; pos_found = 1'b1;
        end
        if (set_count < SET_LIMIT) set_count++;
        if (last_f) begin
            queue_extreme(KIND_MAX,  max_val,  max_pos,  1'b1);
            queue_extreme(KIND_MIN,  min_val,  min_pos,  1'b1);
            queue_extreme(KIND_SMAX, max2_val, max2_pos, set_count >= 2);
            queue_extreme(KIND_SMIN, min2_val, min2_pos, set_count >= 2);
            queue_extreme(KIND_LNEG, neg_val,  neg_pos,  neg_found);
            queue_extreme(KIND_SPOS, pos_val,  pos_pos,  pos_found);
            clear_trackers();
            sets_sent++;
        end
    endtask

    // Offer one element after a random gap and hold it until accepted
    task automatic send_element(input logic signed [31:0] v, input logic last_f);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push    = 1'b1;
        i_value = v;
        i_last  = last_f;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_element(v, last_f);
        elements_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic wait_results_drained();
        stop_sending();
        while (pending_extremes.size() != 0) @(posedge i_clk);
    endtask

    // Pick a value biased toward extremes, zero and duplicates
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3, 4:    return $signed($urandom_range(8)) - 4;
            5, 6:    return $urandom;
            7:       return $urandom_range(1) ? 32'sd1 : -32'sd1;
            default: return $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    task automatic send_random_set(input int len);
        for (int n = 0; n < len; n++) send_element(pick_value(), n == len - 1);
    endtask

    // Drive pop; a nonzero hold_cycles holds it low while it counts down to zero
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            pop = 1'b0;
        end else begin
            pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each popped beat with the oldest expected one
    always @(posedge i_clk) begin
        extreme_beat_t exp_b;
        if (i_rst_n && pop && !empty) begin
            if (pending_extremes.size() == 0) begin
                report_mismatch("beat with none expected, kind", 32'(o_kind), '0);
            end else begin
                exp_b = pending_extremes.pop_front();
                if (o_kind != exp_b.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(exp_b.kind));
                if (o_result_value != exp_b.value)
                    report_mismatch("result_value", o_result_value, exp_b.value);
                if (o_position != exp_b.pos)
                    report_mismatch("position", 32'(o_position), 32'(exp_b.pos));
                if (o_valid_res != exp_b.valid)
                    report_mismatch("valid_res", 32'(o_valid_res), 32'(exp_b.valid));
                if (o_end_of_run != exp_b.eor)
                    report_mismatch("end_of_run", 32'(o_end_of_run), 32'(exp_b.eor));
                beats_checked++;
            end
        end
    end

    // Sets of a single element: no second max or min
    task automatic test_single_element();
        send_element(32'sd5, 1'b1);
        send_element(-32'sd7, 1'b1);
        send_element(32'sd0, 1'b1);
    endtask

    // Repeated max and min: second extremes report the first index
    task automatic test_duplicate_extremes();
        send_element(32'sd3, 1'b0);
        send_element(32'sd9, 1'b0);
        send_element(32'sd9, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sd4, 1'b1);
    endtask

    // Sets missing negatives, positives, or both
    task automatic test_missing_signs();
        send_element(32'sd4, 1'b0);
        send_element(32'sd2, 1'b0);
        send_element(32'sd8, 1'b1);
        send_element(-32'sd4, 1'b0);
        send_element(-32'sd2, 1'b0);
        send_element(-32'sd8, 1'b1);
        send_element(32'sd0, 1'b0);
        send_element(32'sd0, 1'b1);
    endtask

    // Full-scale values around zero and at both ends of the range
    task automatic test_field_extremes();
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(32'sh8000_0000, 1'b1);
    endtask

    // A set longer than the index range: late extremes saturate their position
    task automatic test_index_saturation();
        logic signed [31:0] v;
        for (int n = 0; n < 1100; n++) begin
            case (n)
                1030:    v = 32'sh7fff_ffff;
                1060:    v = 32'sh8000_0000;
                1070:    v = 32'sd1;
                default: v = $signed($urandom_range(2000)) - 1000;
            endcase
            send_element(v, n == 1099);
        end
    endtask

    // Hold off the receiver while short sets pile up and stall the input
    task automatic test_backpressure_fill();
        @(posedge i_clk);
        hold_cycles = 300;
        for (int s = 0; s < 24; s++) send_random_set($urandom_range(1, 2));
        wait_results_drained();
    endtask

    // Random sets under one idle and stall mix
    task automatic test_random_sets(input int idle_pct, input int stall_pct, input int items);
        int start;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = elements_sent;
        while (elements_sent - start < items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
            send_random_set(len);
        end
        wait_results_drained();
    endtask

    initial begin
        clear_trackers();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_element();
        test_duplicate_extremes();
        test_missing_signs();
        test_field_extremes();
        wait_results_drained();
        test_index_saturation();
        wait_results_drained();
        test_backpressure_fill();
        test_random_sets(0, 0, 100);
        test_random_sets(67, 0, 100);
        test_random_sets(0, 67, 100);
        test_random_sets(31, 31, 100);

        stop_sending();
        while (pending_extremes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d elements in %0d sets, %0d result beats compared",
                 elements_sent, sets_sent, beats_checked);
        $display("directed edge sets, index saturation, input stall, four idle/stall mixes");
        if (errors_seen == 0) begin
            $display("array_extremes_with_positions_tb: PASS");
        end else begin
            $display("%0d mismatches", errors_seen);
            $display("array_extremes_with_positions_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
